[sv/assert_macros.svh]
// Assertion helpers for the CSV line validator RTL.
// Expects signals clk and rst_n (synchronous, active low) in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge while out of reset.
`define CSVV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen while out of reset.
`define CSVV_NEVER(label, cond, msg) \
  `CSVV_ASSERT(label, !(cond), msg)

`endif

[sv/csvv_pkg.sv]
// Shared types and constants of the CSV line validator.
// No dependencies; imported by csvv_front, csvv_back and csv_line_validator.
package csvv_pkg;

  localparam int unsigned MAX_COLUMNS = 1024;
  localparam int unsigned MAX_LINES   = 1048576;

  localparam int unsigned CHAR_W = 16;
  localparam int unsigned COL_W  = 11;
  localparam int unsigned LINE_W = 21;

  localparam logic [CHAR_W-1:0] CH_QUOTE = 16'h0022;
  localparam logic [CHAR_W-1:0] CH_COMMA = 16'h002C;

  typedef enum logic [1:0] {
    OP_CHAR = 2'd0,
    OP_EOL  = 2'd1,
    OP_EOD  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    K_CHAR       = 3'd0,
    K_CELL_END   = 3'd1,
    K_ROW_END    = 3'd2,
    K_VALID      = 3'd3,
    K_OPEN_QUOTE = 3'd4,
    K_MISMATCH   = 3'd5,
    K_TOO_MANY   = 3'd6
  } kind_t;

  // Classified request as held in the queue between front and back.
  typedef struct packed {
    op_t               op;
    logic              is_quote;
    logic              is_comma;
    logic [CHAR_W-1:0] ch;
  } item_t;

  // Handshake between queue and back end.
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

endpackage

[sv/csvv_front.sv]
// Front end: accepts input requests, classifies them and queues them.
// Depends on csvv_pkg.
module csvv_front import csvv_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_op,
  input  logic [CHAR_W-1:0] in_ch,
  output q_head_t           head,
  input  logic              pop
);

  item_t       entry_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        push;
  item_t       cls;

  always_comb begin
    cls.op       = op_t'(in_op);
    cls.is_quote = (in_ch == CH_QUOTE);
    cls.is_comma = (in_ch == CH_COMMA);
    cls.ch       = in_ch;
  end

  assign in_ready = (count_r != 2'd2);
  // unused opcode is consumed here and never reaches the back end
  assign push     = in_valid && in_ready && (cls.op != OP_NONE);

  assign head.valid = (count_r != 2'd0);
  assign head.item  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= cls;
    end
  end

endmodule

[sv/csvv_back.sv]
// Back end: parser state, row checks and the registered result stage.
// Depends on csvv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module csvv_back import csvv_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  q_head_t           head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output kind_t             out_kind,
  output logic [CHAR_W-1:0] out_ch,
  output logic [LINE_W-1:0] out_line,
  output logic [COL_W-1:0]  out_cols,
  output logic [COL_W-1:0]  out_exp
);

  logic              inq_r, inq_nxt;
  logic              qp_r, qp_nxt;
  logic [COL_W-1:0]  cols_r, cols_nxt;
  logic [COL_W-1:0]  exp_r, exp_nxt;
  logic              known_r, known_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic              failed_r, failed_nxt;

  logic              ovalid_r, ovalid_nxt;
  kind_t             kind_r;
  logic [CHAR_W-1:0] ch_r;
  logic [LINE_W-1:0] oline_r;
  logic [COL_W-1:0]  ocols_r, oexp_r;

  logic              emit;
  kind_t             r_kind;
  logic [CHAR_W-1:0] r_ch;
  logic [LINE_W-1:0] r_line;
  logic [COL_W-1:0]  r_cols, r_exp;
  logic              eff_inq;
  logic [COL_W:0]    plus2;
  logic [COL_W-1:0]  plus1;
  item_t             it;

  assign it    = head.item;
  assign pop   = head.valid && (!ovalid_r || out_ready);
  // a pending quote that is not doubled closes quote mode first
  assign eff_inq = inq_r && !qp_r;
  assign plus1 = cols_r + COL_W'(1);
  assign plus2 = {1'b0, cols_r} + (COL_W+1)'(2);

  always_comb begin
    inq_nxt    = inq_r;
    qp_nxt     = qp_r;
    cols_nxt   = cols_r;
    exp_nxt    = exp_r;
    known_nxt  = known_r;
    line_nxt   = line_r;
    failed_nxt = failed_r;
    emit   = 1'b0;
    r_kind = K_CHAR;
    r_ch   = '0;
    r_line = line_r;
    r_cols = cols_r;
    r_exp  = known_r ? exp_r : '0;

    case (it.op)
      OP_CHAR: begin
        if (!failed_r) begin
          if (qp_r && it.is_quote) begin
            qp_nxt = 1'b0;
            emit   = 1'b1;
            r_ch   = CH_QUOTE;
          end else if (!qp_r && it.is_quote) begin
            if (inq_r) qp_nxt = 1'b1;
            else       inq_nxt = 1'b1;
          end else begin
            qp_nxt = 1'b0;
            if (qp_r) inq_nxt = 1'b0;
            emit = 1'b1;
            if (it.is_comma && !eff_inq) begin
              if (plus2 > (COL_W+1)'(MAX_COLUMNS)) begin
                failed_nxt = 1'b1;
                r_kind     = K_TOO_MANY;
                r_cols     = plus2[COL_W-1:0];
              end else begin
                cols_nxt = plus1;
                r_kind   = K_CELL_END;
                r_cols   = plus1;
              end
            end else begin
              r_ch = it.ch;
            end
          end
        end
      end
      OP_EOL: begin
        if (!failed_r) begin
          qp_nxt = 1'b0;
          if (qp_r) inq_nxt = 1'b0;
          emit = 1'b1;
          if (eff_inq) begin
            failed_nxt = 1'b1;
            r_kind     = K_OPEN_QUOTE;
          end else if (known_r && (plus1 != exp_r)) begin
            failed_nxt = 1'b1;
            r_kind     = K_MISMATCH;
            r_cols     = plus1;
          end else begin
            if (!known_r) begin
              known_nxt = 1'b1;
              exp_nxt   = plus1;
              r_exp     = plus1;
            end
            r_kind   = K_ROW_END;
            r_cols   = plus1;
            inq_nxt  = 1'b0;
            cols_nxt = '0;
            if (line_r < LINE_W'(MAX_LINES)) line_nxt = line_r + LINE_W'(1);
          end
        end
      end
      OP_EOD: begin
        emit       = !failed_r;
        r_kind     = K_VALID;
        r_line     = line_r - LINE_W'(1);
        r_cols     = '0;
        inq_nxt    = 1'b0;
        qp_nxt     = 1'b0;
        cols_nxt   = '0;
        exp_nxt    = '0;
        known_nxt  = 1'b0;
        line_nxt   = LINE_W'(1);
        failed_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (pop)            ovalid_nxt = emit;
    else if (out_ready) ovalid_nxt = 1'b0;
    else                ovalid_nxt = ovalid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_r    <= 1'b0;
      qp_r     <= 1'b0;
      cols_r   <= '0;
      exp_r    <= '0;
      known_r  <= 1'b0;
      line_r   <= LINE_W'(1);
      failed_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
      if (pop) begin
        inq_r    <= inq_nxt;
        qp_r     <= qp_nxt;
        cols_r   <= cols_nxt;
        exp_r    <= exp_nxt;
        known_r  <= known_nxt;
        line_r   <= line_nxt;
        failed_r <= failed_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      kind_r  <= r_kind;
      ch_r    <= r_ch;
      oline_r <= r_line;
      ocols_r <= r_cols;
      oexp_r  <= r_exp;
    end
  end

  assign out_valid = ovalid_r;
  assign out_kind  = kind_r;
  assign out_ch    = ch_r;
  assign out_line  = oline_r;
  assign out_cols  = ocols_r;
  assign out_exp   = oexp_r;

  `CSVV_ASSERT(a_pending_in_quotes, qp_r |-> inq_r, "quote pending outside quote mode")
  `CSVV_NEVER(a_line_range, (line_r == '0) || (line_r > LINE_W'(MAX_LINES)), "line out of range")
  `CSVV_NEVER(a_cols_range, {1'b0, cols_r} >= (COL_W+1)'(MAX_COLUMNS), "column count overflow")
  `CSVV_ASSERT(a_expected_clear, !known_r |-> (exp_r == '0), "expected count set while unknown")
  `CSVV_ASSERT(a_doc_end_reset, (pop && (it.op == OP_EOD)) |=> (!failed_r && (line_r == LINE_W'(1))),
               "state not cleared at end of document")

endmodule

[sv/csv_line_validator.sv]
// Top level of the CSV line validator: front end, queue and back end.
// Depends on csvv_pkg, csvv_front and csvv_back.
//
//  channel | dir | tdata                                   | tuser
//  in_     | in  | character[15:0]                         | operation[1:0]
//  out_    | out | cell_char, line_number, column_count,   | kind[2:0]
//          |     | expected_columns (64 bits, zero padded) |
//
// One request per cycle sustained while the output is not stalled; a result is registered
// at the edge that takes its request from the two-entry queue; requests never bypass the queue.
// The back end advances whenever the output register is empty or being taken, so a stalled
// output fills the queue and then drops in_tready.
// Synchronous active-low reset; no clearing pass, in_tready is high as soon as reset is released.
module csv_line_validator import csvv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] character
  input  logic [1:0]  in_tuser,   // [1:0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [15:0] cell_char, [36:16] line_number,
                                  // [47:37] column_count, [58:48] expected_columns
  output logic [2:0]  out_tuser   // [2:0] kind
);

  q_head_t           head;
  logic              pop;
  kind_t             kind;
  logic [CHAR_W-1:0] ch;
  logic [LINE_W-1:0] line;
  logic [COL_W-1:0]  cols, expc;

  csvv_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_op    (in_tuser),
    .in_ch    (in_tdata),
    .head     (head),
    .pop      (pop)
  );

  csvv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (kind),
    .out_ch    (ch),
    .out_line  (line),
    .out_cols  (cols),
    .out_exp   (expc)
  );

  assign out_tuser = kind;
  assign out_tdata = {5'd0, expc, cols, line, ch};

endmodule
